FILE: rtl/dcwo_pkg.sv
`default_nettype none
package dcwo_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = 8;
	localparam int SAMPLE_W    = 12;
	localparam int FRAC_W      = 16;
	localparam int PHASE_W     = 24;
	localparam int COEF_W      = 15;
	localparam int H_W         = 32;
	localparam int MAG_W       = H_W - 1;
	localparam int PROD_W      = MAG_W + FRAC_W;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Which coefficient the Horner add step folds in.
	localparam logic [1:0] SEL_A1 = 2'd0;
	localparam logic [1:0] SEL_A2 = 2'd1;
	localparam logic [1:0] SEL_A3 = 2'd2;

	typedef struct packed {
		logic       phase_adv;
		logic       tbl_wr;
		logic       rd_en;
		logic [1:0] rd_offset;
		logic       shift;
		logic       coef;
		logic       mul;
		logic       add;
		logic [1:0] add_sel;
		logic       out_load;
	} cmd_t;

endpackage
`default_nettype wire

FILE: rtl/dds_cubic_wavetable_oscillator_core.sv
`default_nettype none
// Wave table oscillator with four-point cubic interpolation.
// Input channel (in_valid/in_ready): each transfer carries op, entry_index and
// entry_value. A write op stores entry_value into the 256-entry table in the
// transfer cycle and produces no result; writes can follow back to back.
// A tick op advances the phase by phase_increment and yields one sample on
// the output channel (out_valid/out_ready).
// A tick runs from its transfer to out_valid through four reads on the
// single table port, a step forming the coefficients, and three multiply/add
// passes through the one shared multiplier. The next item is taken in the
// cycle after the result is loaded. The result sits in an output register,
// so a new tick can start while the receiver holds off; only its final load
// waits for that slot. The user must write phase_increment through
// cfg_we/cfg_wdata only while the block is idle; it is not enforced. Reset
// clears the phase, the increment and both handshakes; the table keeps no
// reset value and must be written before ticks read it.
module dds_cubic_wavetable_oscillator_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            op,
	input  wire logic [dcwo_pkg::ADDR_W-1:0]     entry_index,
	input  wire logic [dcwo_pkg::SAMPLE_W-1:0]   entry_value,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [dcwo_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic                            cfg_we,
	input  wire logic [dcwo_pkg::PHASE_W-1:0]    cfg_wdata
);

	dcwo_pkg::cmd_t cmd;

	dcwo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	dcwo_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.sample      (sample)
	);

`ifndef SYNTH
	// A tick keeps the block busy for the cycle after its transfer.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && op == dcwo_pkg::OP_TICK) |=> !in_ready)
		else $error("block accepted an item right after a tick");

	// A table write never leaves the block busy.
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && op == dcwo_pkg::OP_WRITE) |=> in_ready)
		else $error("table write stalled the input");

	// A new result is loaded only from the final state, when no input is taken.
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !in_ready)
		else $error("result loaded while idle");

	// Results are loaded only into a free or draining output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

FILE: rtl/dcwo_ctrl.sv
`default_nettype none
module dcwo_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          op,
	input  wire logic          out_ready,
	output logic               in_ready,
	output logic               out_valid,
	output dcwo_pkg::cmd_t     cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_READ = 7'b0000010,
		S_LAST = 7'b0000100,
		S_COEF = 7'b0001000,
		S_MUL  = 7'b0010000,
		S_ADD  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] cnt_q, cnt_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op == dcwo_pkg::OP_WRITE) begin
						cmd.tbl_wr = 1'b1;
					end else begin
						cmd.phase_adv = 1'b1;
						cnt_d         = 2'd0;
						state_d       = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_offset = cnt_q;
				cmd.shift     = (cnt_q != 2'd0);
				cnt_d         = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				cmd.shift = 1'b1;
				state_d   = S_COEF;
			end
			S_COEF: begin
				cmd.coef = 1'b1;
				cnt_d    = 2'd0;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add     = 1'b1;
				cmd.add_sel = cnt_q;
				if (cnt_q == dcwo_pkg::SEL_A3) begin
					state_d = S_DONE;
				end else begin
					cnt_d   = cnt_q + 2'd1;
					state_d = S_MUL;
				end
			end
			S_DONE: begin
				// The result waits here while the previous one is still unclaimed.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dcwo_dp.sv
`default_nettype none
module dcwo_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire dcwo_pkg::cmd_t                  cmd,
	input  wire logic [dcwo_pkg::ADDR_W-1:0]     entry_index,
	input  wire logic [dcwo_pkg::SAMPLE_W-1:0]   entry_value,
	input  wire logic                            cfg_we,
	input  wire logic [dcwo_pkg::PHASE_W-1:0]    cfg_wdata,
	output logic      [dcwo_pkg::SAMPLE_W-1:0]   sample
);

	logic [dcwo_pkg::SAMPLE_W-1:0] mem [dcwo_pkg::TABLE_DEPTH];
	logic [dcwo_pkg::SAMPLE_W-1:0] rd_q;
	logic [dcwo_pkg::SAMPLE_W-1:0] y_q [4];

	logic [dcwo_pkg::PHASE_W-1:0]  phase_q;
	logic [dcwo_pkg::PHASE_W-1:0]  inc_q;
	logic [dcwo_pkg::ADDR_W-1:0]   base;
	logic [dcwo_pkg::FRAC_W-1:0]   frac;
	logic [dcwo_pkg::ADDR_W-1:0]   rd_addr;

	logic signed [dcwo_pkg::COEF_W-1:0] ys [4];
	logic signed [dcwo_pkg::COEF_W-1:0] a0, a1, a2;
	logic signed [dcwo_pkg::COEF_W-1:0] a1_q, a2_q, a3_q, a_sel;

	logic signed [dcwo_pkg::H_W-1:0]    h_q;
	logic        [dcwo_pkg::H_W-1:0]    h_abs;
	logic        [dcwo_pkg::PROD_W-1:0] prod_q;
	logic                               neg_q;
	logic        [dcwo_pkg::H_W-1:0]    m_ext;
	logic signed [dcwo_pkg::H_W-1:0]    m_signed;
	logic signed [dcwo_pkg::H_W-1:0]    a_shifted;
	logic        [dcwo_pkg::SAMPLE_W-1:0] sat;

	assign base = phase_q[dcwo_pkg::PHASE_W-1:dcwo_pkg::FRAC_W];
	assign frac = phase_q[dcwo_pkg::FRAC_W-1:0];
	// Offsets 0..3 fetch the entries at base-1 .. base+2, wrapping around the table.
	assign rd_addr = base + dcwo_pkg::ADDR_W'(cmd.rd_offset) - dcwo_pkg::ADDR_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			inc_q   <= '0;
		end else begin
			if (cfg_we) begin
				inc_q <= cfg_wdata;
			end
			if (cmd.phase_adv) begin
				phase_q <= phase_q + inc_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_wr) begin
			mem[entry_index] <= entry_value;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			y_q[0] <= y_q[1];
			y_q[1] <= y_q[2];
			y_q[2] <= y_q[3];
			y_q[3] <= rd_q;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ys[k] = signed'({{(dcwo_pkg::COEF_W-dcwo_pkg::SAMPLE_W){1'b0}}, y_q[k]});
		end
		a0 = ys[3] - ys[2] - ys[0] + ys[1];
		a1 = ys[0] - ys[1] - a0;
		a2 = ys[2] - ys[0];
	end

	always_comb begin
		case (cmd.add_sel)
			dcwo_pkg::SEL_A1: a_sel = a1_q;
			dcwo_pkg::SEL_A2: a_sel = a2_q;
			default:          a_sel = a3_q;
		endcase
	end

	assign h_abs     = h_q[dcwo_pkg::H_W-1] ? (~h_q + 1'b1) : h_q;
	assign m_ext     = {1'b0, prod_q[dcwo_pkg::PROD_W-1:dcwo_pkg::FRAC_W]};
	assign m_signed  = neg_q ? signed'(~m_ext + 1'b1) : signed'(m_ext);
	assign a_shifted = signed'({{(dcwo_pkg::H_W-dcwo_pkg::COEF_W-dcwo_pkg::FRAC_W){a_sel[dcwo_pkg::COEF_W-1]}},
		a_sel, {dcwo_pkg::FRAC_W{1'b0}}});

	// Horner evaluation: one multiply and one add per coefficient, both registered.
	always_ff @(posedge clk) begin
		if (cmd.coef) begin
			a1_q <= a1;
			a2_q <= a2;
			a3_q <= ys[1];
			h_q  <= signed'({{(dcwo_pkg::H_W-dcwo_pkg::COEF_W-dcwo_pkg::FRAC_W){a0[dcwo_pkg::COEF_W-1]}},
				a0, {dcwo_pkg::FRAC_W{1'b0}}});
		end else if (cmd.add) begin
			h_q <= m_signed + a_shifted;
		end
		if (cmd.mul) begin
			prod_q <= h_abs[dcwo_pkg::MAG_W-1:0] * frac;
			neg_q  <= h_q[dcwo_pkg::H_W-1];
		end
	end

	// The integer part truncates toward zero; any negative value clamps to zero anyway.
	always_comb begin
		if (h_q[dcwo_pkg::H_W-1]) begin
			sat = '0;
		end else if (|h_q[dcwo_pkg::H_W-2:dcwo_pkg::FRAC_W+dcwo_pkg::SAMPLE_W]) begin
			sat = '1;
		end else begin
			sat = h_q[dcwo_pkg::FRAC_W+dcwo_pkg::SAMPLE_W-1:dcwo_pkg::FRAC_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample <= sat;
		end
	end

endmodule
`default_nettype wire
